FILE: src/wss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_pkg
// Shared widths, constants, types and saturation helpers for the weighted
// sample statistics unit and its arithmetic units.
// ----------------------------------------------------------------------------
package wss_pkg;

    // parameter defaults
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int DEV_FRACTION_BITS = 4;

    // fixed field widths
    localparam int TIME_W   = 32;
    localparam int WEIGHT_W = 16;
    localparam int ACC_W    = 48;
    localparam int SQS_W    = 64;
    localparam int MEAN_W   = 24;
    localparam int VAR_W    = 56;
    localparam int DEV_W    = 32;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 2;

    // arithmetic unit widths
    localparam int DIV_NUM_W = 128;
    localparam int DIV_DEN_W = ACC_W + 1;
    localparam int DIV_CNT_W = 7;
    localparam int MUL_A_W   = SQS_W;
    localparam int MUL_B_W   = ACC_W;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = 6;
    localparam int SQRT_X_W  = 64;
    localparam int ROOT_W    = SQRT_X_W / 2;
    localparam int ROOT_CNT_W = 5;

    // reset value of the interval length register
    localparam logic [TIME_W-1:0] INTERVAL_RESET = TIME_W'(1000);

    // clamp points
    localparam logic [MEAN_W-1:0] MEAN_CAP = {1'b1, {(MEAN_W-1){1'b0}}};
    localparam logic [DIV_NUM_W-1:0] VAR_MAX = {{(DIV_NUM_W-VAR_W){1'b0}}, {VAR_W{1'b1}}};

    // divider control
    typedef struct packed {
        logic start;
        logic wide;
    } div_ctl_t;

    // unsigned add result clamped to the accumulator width
    function automatic logic [ACC_W-1:0] sat_u48(input logic [ACC_W:0] s);
        logic [ACC_W-1:0] r;
        r = s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
        return r;
    endfunction

    // signed add result clamped to the signed accumulator range
    function automatic logic signed [ACC_W-1:0] sat_s48(input logic signed [ACC_W:0] s);
        logic signed [ACC_W-1:0] r;
        if (s[ACC_W] != s[ACC_W-1])
        begin
            r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            r = s[ACC_W-1:0];
        end
        return r;
    endfunction

    // fixed-point mean from a magnitude quotient, clamped to the signed range
    function automatic logic signed [MEAN_W-1:0] mean_fix(input logic neg,
                                                          input logic [63:0] quo);
        logic [MEAN_W-1:0] res;
        res = (quo > 64'(MEAN_CAP)) ? MEAN_CAP : quo[MEAN_W-1:0];
        if (neg)
        begin
            res = -res;
        end
        else if (res == MEAN_CAP)
        begin
            res = MEAN_CAP - MEAN_W'(1);
        end
        return res;
    endfunction

endpackage

FILE: src/wss_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_div
// Restoring divider, one quotient bit per cycle. Wide mode runs 128 steps on
// the full dividend, narrow mode 64 steps on its low half.
// ----------------------------------------------------------------------------
module wss_div
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  wss_pkg::div_ctl_t                  ctl,
    input  logic [wss_pkg::DIV_NUM_W-1:0]      num,
    input  logic [wss_pkg::DIV_DEN_W-1:0]      den,
    output logic                               done,
    output logic [wss_pkg::DIV_NUM_W-1:0]      quo,
    output logic [wss_pkg::DIV_DEN_W-1:0]      rem
);

    localparam int NW = wss_pkg::DIV_NUM_W;
    localparam int DW = wss_pkg::DIV_DEN_W;

    logic                              busy_reg;
    logic                              done_reg;
    logic [wss_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [NW-1:0]                     n_reg;
    logic [DW-1:0]                     r_reg;
    logic [DW-1:0]                     d_reg;
    logic [DW:0]                       trial;
    logic                              ge;
    logic [DW:0]                       diff;

    // one compare and subtract step
    always_comb
    begin
        trial = {r_reg, n_reg[NW-1]};
        ge    = trial >= {1'b0, d_reg};
        diff  = trial - {1'b0, d_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (cnt_reg == '0))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            n_reg   <= ctl.wide ? num : {num[NW/2-1:0], {(NW/2){1'b0}}};
            cnt_reg <= ctl.wide ? wss_pkg::DIV_CNT_W'(NW - 1)
                                : wss_pkg::DIV_CNT_W'(NW / 2 - 1);
            r_reg   <= '0;
            d_reg   <= den;
        end
        else if (busy_reg)
        begin
            n_reg   <= {n_reg[NW-2:0], ge};
            r_reg   <= ge ? diff[DW-1:0] : trial[DW-1:0];
            cnt_reg <= cnt_reg - wss_pkg::DIV_CNT_W'(1);
        end
    end

    assign done = done_reg;
    assign quo  = n_reg;
    assign rem  = r_reg;

endmodule

FILE: src/wss_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_mul
// Shift-and-add multiplier, one multiplier bit per cycle, 48 steps.
// ----------------------------------------------------------------------------
module wss_mul
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [wss_pkg::MUL_A_W-1:0]      a,
    input  logic [wss_pkg::MUL_B_W-1:0]      b,
    output logic                             done,
    output logic [wss_pkg::MUL_P_W-1:0]      prod
);

    localparam int PW = wss_pkg::MUL_P_W;

    logic                              busy_reg;
    logic                              done_reg;
    logic [wss_pkg::MUL_CNT_W-1:0]     cnt_reg;
    logic [PW-1:0]                     acc_reg;
    logic [PW-1:0]                     a_reg;
    logic [wss_pkg::MUL_B_W-1:0]       b_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (cnt_reg == '0))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // accumulate shifted multiplicand per set multiplier bit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= PW'(a);
            b_reg   <= b;
            cnt_reg <= wss_pkg::MUL_CNT_W'(wss_pkg::MUL_B_W - 1);
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg   <= {a_reg[PW-2:0], 1'b0};
            b_reg   <= {1'b0, b_reg[wss_pkg::MUL_B_W-1:1]};
            cnt_reg <= cnt_reg - wss_pkg::MUL_CNT_W'(1);
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

FILE: src/wss_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_sqrt
// Digit-by-digit integer square root, one root bit per cycle, 32 steps.
// ----------------------------------------------------------------------------
module wss_sqrt
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [wss_pkg::SQRT_X_W-1:0]     x,
    output logic                             done,
    output logic [wss_pkg::ROOT_W-1:0]       root
);

    localparam int XW = wss_pkg::SQRT_X_W;
    localparam int RW = wss_pkg::ROOT_W;

    logic                              busy_reg;
    logic                              done_reg;
    logic [wss_pkg::ROOT_CNT_W-1:0]    cnt_reg;
    logic [XW-1:0]                     x_reg;
    logic [RW+1:0]                     rem_reg;
    logic [RW-1:0]                     root_reg;
    logic [RW+3:0]                     r4;
    logic [RW+3:0]                     t4;
    logic                              ge;
    logic [RW+3:0]                     diff;

    // bring down two bits and try the next root bit
    always_comb
    begin
        r4   = {rem_reg, x_reg[XW-1:XW-2]};
        t4   = {2'b00, root_reg, 2'b01};
        ge   = r4 >= t4;
        diff = r4 - t4;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (cnt_reg == '0))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= x;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= wss_pkg::ROOT_CNT_W'(RW - 1);
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[XW-3:0], 2'b00};
            rem_reg  <= ge ? diff[RW+1:0] : r4[RW+1:0];
            root_reg <= {root_reg[RW-2:0], ge};
            cnt_reg  <= cnt_reg - wss_pkg::ROOT_CNT_W'(1);
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: src/weighted_sample_statistics_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_sample_statistics_unit
// Running weighted min, max, mean, variance and deviation with closing of
// fixed-length time intervals, computed by a sequencer over shared units.
// ----------------------------------------------------------------------------
// Usage:
//   Input transaction (item_valid / item_stall): command, sample, weight, now.
//   Command 0 adds a weighted sample, command 1 restarts all statistics.
//   Output transaction (result_valid / result_stall): one result per input,
//   the statistics after that input.
//   interval_length is to be written over the APB port only while the block
//   is idle; the block itself does not enforce this. item_stall is high from
//   acceptance until the result is in the output register; one transaction
//   is in work at a time. An add runs a 64-step split division when its time
//   is at or past the interval end, then a 64-step division for the mean of
//   the closed interval when just one interval has closed and it holds weight;
//   then the 64-step mean division when the total weight is nonzero, the two
//   48-step products when it is at least two, and the two 128-step variance
//   divisions when the difference is positive.
//   The next transaction is taken while a result still waits; a finished
//   result waits in the last state while the receiver stalls.
//   Reset clears all statistics, sets interval_length to 1000 and the first
//   interval end to 1000.
// ----------------------------------------------------------------------------
module weighted_sample_statistics_unit #(
    parameter int SAMPLE_BITS   = wss_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = wss_pkg::FRACTION_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                command,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic [wss_pkg::WEIGHT_W-1:0]        weight,
    input  logic [wss_pkg::TIME_W-1:0]          now,
    // output channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [wss_pkg::ACC_W-1:0]           total_weight,
    output logic signed [SAMPLE_BITS-1:0]       minimum,
    output logic signed [SAMPLE_BITS-1:0]       maximum,
    output logic signed [wss_pkg::MEAN_W-1:0]   mean,
    output logic signed [wss_pkg::MEAN_W-1:0]   interval_mean,
    output logic [wss_pkg::VAR_W-1:0]           variance,
    output logic [wss_pkg::DEV_W-1:0]           deviation,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wss_pkg::ADDR_W-1:0]          paddr,
    input  logic [wss_pkg::DATA_W-1:0]          pwdata,
    output logic [wss_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    localparam int ACC_W  = wss_pkg::ACC_W;
    localparam int TIME_W = wss_pkg::TIME_W;
    localparam int PROD_W = SAMPLE_BITS + wss_pkg::WEIGHT_W + 1;
    localparam int SQ_RSH = (FRACTION_BITS >= 2 * wss_pkg::DEV_FRACTION_BITS)
                          ? FRACTION_BITS - 2 * wss_pkg::DEV_FRACTION_BITS : 0;
    localparam int SQ_LSH = (FRACTION_BITS < 2 * wss_pkg::DEV_FRACTION_BITS)
                          ? 2 * wss_pkg::DEV_FRACTION_BITS - FRACTION_BITS : 0;

    typedef enum logic [4:0] {
        S_IDLE, S_PROD, S_SQ, S_KDIV, S_KWAIT, S_IMDIV, S_IMWAIT, S_UPDATE,
        S_MDIV, S_MWAIT, S_MULA, S_MULAW, S_MULB, S_MULBW, S_VCMP, S_VD1W,
        S_VD2, S_VD2W, S_SQRT, S_SQW, S_DONE
    } state_t;

    state_t                               state_reg;

    // configuration
    logic [TIME_W-1:0]                    ilen_reg;

    // statistics
    logic [ACC_W-1:0]                     wtot_reg;
    logic signed [SAMPLE_BITS-1:0]        smallest_reg;
    logic signed [SAMPLE_BITS-1:0]        largest_reg;
    logic signed [ACC_W-1:0]              wsum_reg;
    logic [wss_pkg::SQS_W-1:0]            qsum_reg;
    logic [TIME_W-1:0]                    iend_reg;
    logic signed [ACC_W-1:0]              isum_reg;
    logic [ACC_W-1:0]                     iwt_reg;
    logic signed [wss_pkg::MEAN_W-1:0]    imean_reg;

    // result register
    logic                                 result_valid_reg;
    logic [ACC_W-1:0]                     total_weight_reg;
    logic signed [SAMPLE_BITS-1:0]        minimum_reg;
    logic signed [SAMPLE_BITS-1:0]        maximum_reg;
    logic signed [wss_pkg::MEAN_W-1:0]    mean_out_reg;
    logic signed [wss_pkg::MEAN_W-1:0]    imean_out_reg;
    logic [wss_pkg::VAR_W-1:0]            variance_reg;
    logic [wss_pkg::DEV_W-1:0]            deviation_reg;

    // working registers
    logic                                 cmd_reg;
    logic signed [SAMPLE_BITS-1:0]        sample_reg;
    logic [wss_pkg::WEIGHT_W-1:0]         weight_reg;
    logic [TIME_W-1:0]                    now_reg;
    logic signed [PROD_W-1:0]             prod_reg;
    logic [wss_pkg::SQS_W-1:0]            sq_reg;
    logic                                 close_reg;
    logic [TIME_W-1:0]                    krem_reg;
    logic [wss_pkg::MUL_P_W-1:0]          a_reg;
    logic signed [wss_pkg::MEAN_W-1:0]    mean_reg;
    logic [wss_pkg::VAR_W-1:0]            var_reg;

    // combinational helpers
    logic [TIME_W-1:0]                    eff_len;
    logic [ACC_W-1:0]                     wsum_mag;
    logic [ACC_W-1:0]                     isum_mag;
    logic [PROD_W-1:0]                    prod_abs;
    logic [63:0]                          pm64;
    logic [31:0]                          pm_lo;
    logic [63:0]                          sq_full;
    logic [TIME_W:0]                      rs_end;
    logic [TIME_W:0]                      cl_end;
    logic [ACC_W:0]                       wt_sum;
    logic signed [ACC_W:0]                ws_sum;
    logic [wss_pkg::SQS_W:0]              qs_sum;
    logic signed [ACC_W-1:0]              ib_sum;
    logic [ACC_W-1:0]                     ib_wt;
    logic signed [ACC_W:0]                is_sum;
    logic [ACC_W:0]                       iw_sum;
    logic [wss_pkg::MUL_P_W-1:0]          var_diff;
    logic                                 var_le;
    logic                                 accept;
    logic                                 out_free;
    logic                                 cfg_write;

    // shared unit ports
    wss_pkg::div_ctl_t                    div_ctl;
    logic [wss_pkg::DIV_NUM_W-1:0]        div_num;
    logic [wss_pkg::DIV_DEN_W-1:0]        div_den;
    logic                                 div_done;
    logic [wss_pkg::DIV_NUM_W-1:0]        div_quo;
    logic [wss_pkg::DIV_DEN_W-1:0]        div_rem;
    logic                                 mul_start;
    logic [wss_pkg::MUL_A_W-1:0]          mul_a;
    logic [wss_pkg::MUL_B_W-1:0]          mul_b;
    logic                                 mul_done;
    logic [wss_pkg::MUL_P_W-1:0]          mul_prod;
    logic                                 sqrt_start;
    logic [wss_pkg::SQRT_X_W-1:0]         sqrt_x;
    logic                                 sqrt_done;
    logic [wss_pkg::ROOT_W-1:0]           sqrt_root;

    // handshakes
    assign accept    = item_valid && (state_reg == S_IDLE);
    assign out_free  = !result_valid_reg || !result_stall;
    assign cfg_write = psel && penable && pwrite;

    // magnitudes, interval ends and accumulator sums
    always_comb
    begin
        eff_len  = (ilen_reg == '0) ? TIME_W'(1) : ilen_reg;
        wsum_mag = wsum_reg[ACC_W-1] ? -wsum_reg : wsum_reg;
        isum_mag = isum_reg[ACC_W-1] ? -isum_reg : isum_reg;
        prod_abs = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
        pm64     = 64'(prod_abs);
        pm_lo    = pm64[31:0];
        sq_full  = pm_lo * pm_lo;
        rs_end   = {1'b0, now_reg} + {1'b0, eff_len};
        cl_end   = {1'b0, now_reg} - {1'b0, krem_reg} + {1'b0, eff_len};
        wt_sum   = {1'b0, wtot_reg} + (ACC_W + 1)'(weight_reg);
        ws_sum   = (ACC_W + 1)'(wsum_reg) + (ACC_W + 1)'(prod_reg);
        qs_sum   = {1'b0, qsum_reg} + {1'b0, sq_reg};
        ib_sum   = close_reg ? '0 : isum_reg;
        ib_wt    = close_reg ? '0 : iwt_reg;
        is_sum   = (ACC_W + 1)'(ib_sum) + (ACC_W + 1)'(prod_reg);
        iw_sum   = {1'b0, ib_wt} + (ACC_W + 1)'(weight_reg);
        var_diff = a_reg - mul_prod;
        var_le   = a_reg <= mul_prod;
    end

    // shared unit operands by sequencer step
    always_comb
    begin
        div_ctl    = '0;
        div_num    = '0;
        div_den    = '0;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        sqrt_start = 1'b0;
        sqrt_x     = (64'(var_reg) >> SQ_RSH) << SQ_LSH;
        unique case (state_reg)
            S_KDIV:
            begin
                div_ctl.start = 1'b1;
                div_num       = 128'(now_reg - iend_reg);
                div_den       = wss_pkg::DIV_DEN_W'(eff_len);
            end
            S_IMDIV:
            begin
                div_ctl.start = 1'b1;
                div_num       = 128'(64'(isum_mag) << FRACTION_BITS);
                div_den       = wss_pkg::DIV_DEN_W'(iwt_reg);
            end
            S_MDIV:
            begin
                div_ctl.start = wtot_reg != '0;
                div_num       = 128'(64'(wsum_mag) << FRACTION_BITS);
                div_den       = wss_pkg::DIV_DEN_W'(wtot_reg);
            end
            S_MULA:
            begin
                mul_start = wtot_reg[ACC_W-1:1] != '0;
                mul_a     = qsum_reg;
                mul_b     = wtot_reg;
            end
            S_MULB:
            begin
                mul_start = 1'b1;
                mul_a     = wss_pkg::MUL_A_W'(wsum_mag);
                mul_b     = wsum_mag;
            end
            S_VCMP:
            begin
                div_ctl.start = !var_le;
                div_ctl.wide  = 1'b1;
                div_num       = 128'(var_diff) << FRACTION_BITS;
                div_den       = wss_pkg::DIV_DEN_W'(wtot_reg);
            end
            S_VD2:
            begin
                div_ctl.start = 1'b1;
                div_ctl.wide  = 1'b1;
                div_num       = div_quo;
                div_den       = wss_pkg::DIV_DEN_W'(wtot_reg) + wss_pkg::DIV_DEN_W'(1);
            end
            S_SQRT:
            begin
                sqrt_start = 1'b1;
            end
            default:
            begin
                div_ctl = '0;
            end
        endcase
    end

    // sequencer, statistics and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ilen_reg         <= wss_pkg::INTERVAL_RESET;
            wtot_reg         <= '0;
            smallest_reg     <= '0;
            largest_reg      <= '0;
            wsum_reg         <= '0;
            qsum_reg         <= '0;
            iend_reg         <= wss_pkg::INTERVAL_RESET;
            isum_reg         <= '0;
            iwt_reg          <= '0;
            imean_reg        <= '0;
            result_valid_reg <= 1'b0;
            total_weight_reg <= '0;
            minimum_reg      <= '0;
            maximum_reg      <= '0;
            mean_out_reg     <= '0;
            imean_out_reg    <= '0;
            variance_reg     <= '0;
            deviation_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                ilen_reg <= pwdata;
            end

            if ((state_reg == S_DONE) && out_free)
            begin
                result_valid_reg <= 1'b1;
                total_weight_reg <= wtot_reg;
                minimum_reg      <= (wtot_reg != '0) ? smallest_reg : '0;
                maximum_reg      <= (wtot_reg != '0) ? largest_reg : '0;
                mean_out_reg     <= mean_reg;
                imean_out_reg    <= imean_reg;
                variance_reg     <= var_reg;
                deviation_reg    <= sqrt_root;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        state_reg <= S_PROD;
                    end
                end
                S_PROD:
                begin
                    if (cmd_reg)
                    begin
                        // restart: clear and open an interval at now
                        wtot_reg     <= '0;
                        smallest_reg <= '0;
                        largest_reg  <= '0;
                        wsum_reg     <= '0;
                        qsum_reg     <= '0;
                        isum_reg     <= '0;
                        iwt_reg      <= '0;
                        imean_reg    <= '0;
                        iend_reg     <= rs_end[TIME_W] ? '1 : rs_end[TIME_W-1:0];
                        state_reg    <= S_MDIV;
                    end
                    else
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    state_reg <= (now_reg >= iend_reg) ? S_KDIV : S_UPDATE;
                end
                S_KDIV:
                begin
                    state_reg <= S_KWAIT;
                end
                S_KWAIT:
                begin
                    if (div_done)
                    begin
                        if ((div_quo == '0) && (iwt_reg != '0))
                        begin
                            state_reg <= S_IMDIV;
                        end
                        else
                        begin
                            imean_reg <= '0;
                            state_reg <= S_UPDATE;
                        end
                    end
                end
                S_IMDIV:
                begin
                    state_reg <= S_IMWAIT;
                end
                S_IMWAIT:
                begin
                    if (div_done)
                    begin
                        imean_reg <= wss_pkg::mean_fix(isum_reg[ACC_W-1], div_quo[63:0]);
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    // extremes, totals and interval sums
                    if (wtot_reg == '0)
                    begin
                        smallest_reg <= sample_reg;
                        largest_reg  <= sample_reg;
                    end
                    else if (sample_reg < smallest_reg)
                    begin
                        smallest_reg <= sample_reg;
                    end
                    else if (sample_reg > largest_reg)
                    begin
                        largest_reg <= sample_reg;
                    end
                    wtot_reg <= wss_pkg::sat_u48(wt_sum);
                    wsum_reg <= wss_pkg::sat_s48(ws_sum);
                    qsum_reg <= qs_sum[wss_pkg::SQS_W] ? '1 : qs_sum[wss_pkg::SQS_W-1:0];
                    isum_reg <= wss_pkg::sat_s48(is_sum);
                    iwt_reg  <= wss_pkg::sat_u48(iw_sum);
                    if (close_reg)
                    begin
                        iend_reg <= cl_end[TIME_W] ? '1 : cl_end[TIME_W-1:0];
                    end
                    state_reg <= S_MDIV;
                end
                S_MDIV:
                begin
                    state_reg <= (wtot_reg != '0) ? S_MWAIT : S_MULA;
                end
                S_MWAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_MULA;
                    end
                end
                S_MULA:
                begin
                    state_reg <= (wtot_reg[ACC_W-1:1] != '0) ? S_MULAW : S_SQRT;
                end
                S_MULAW:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_MULB;
                    end
                end
                S_MULB:
                begin
                    state_reg <= S_MULBW;
                end
                S_MULBW:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_VCMP;
                    end
                end
                S_VCMP:
                begin
                    state_reg <= var_le ? S_SQRT : S_VD1W;
                end
                S_VD1W:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_VD2;
                    end
                end
                S_VD2:
                begin
                    state_reg <= S_VD2W;
                end
                S_VD2W:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    state_reg <= S_SQW;
                end
                S_SQW:
                begin
                    if (sqrt_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // item capture and intermediate results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command;
            sample_reg <= sample;
            weight_reg <= weight;
            now_reg    <= now;
        end
        if (state_reg == S_PROD)
        begin
            prod_reg <= sample_reg * $signed({1'b0, weight_reg});
        end
        if (state_reg == S_SQ)
        begin
            sq_reg    <= (pm64[63:32] != '0) ? '1 : sq_full;
            close_reg <= now_reg >= iend_reg;
        end
        if ((state_reg == S_KWAIT) && div_done)
        begin
            krem_reg <= div_rem[TIME_W-1:0];
        end
        if (state_reg == S_MDIV)
        begin
            mean_reg <= '0;
        end
        if ((state_reg == S_MWAIT) && div_done)
        begin
            mean_reg <= wss_pkg::mean_fix(wsum_reg[ACC_W-1], div_quo[63:0]);
        end
        if ((state_reg == S_MULA) || ((state_reg == S_VCMP) && var_le))
        begin
            var_reg <= '0;
        end
        if ((state_reg == S_MULAW) && mul_done)
        begin
            a_reg <= mul_prod;
        end
        if ((state_reg == S_VD2W) && div_done)
        begin
            var_reg <= (div_quo > wss_pkg::VAR_MAX) ? '1 : div_quo[wss_pkg::VAR_W-1:0];
        end
    end

    // shared arithmetic units
    wss_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    wss_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    wss_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .x     (sqrt_x),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // ports
    assign item_stall    = state_reg != S_IDLE;
    assign result_valid  = result_valid_reg;
    assign total_weight  = total_weight_reg;
    assign minimum       = minimum_reg;
    assign maximum       = maximum_reg;
    assign mean          = mean_out_reg;
    assign interval_mean = imean_out_reg;
    assign variance      = variance_reg;
    assign deviation     = deviation_reg;
    assign prdata        = ilen_reg;
    assign pready        = 1'b1;

    // variance is zero for a total weight of at most one
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && (total_weight_reg[ACC_W-1:1] == '0) |-> variance_reg == '0)
        else $error("variance nonzero with total weight at most one");

    // deviation is zero whenever variance is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && (variance_reg == '0) |-> deviation_reg == '0)
        else $error("deviation nonzero with zero variance");

    // reported extremes stay ordered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && (total_weight_reg != '0) |-> minimum_reg <= maximum_reg)
        else $error("minimum above maximum");

    // an accepted transaction raises item_stall, blocking further input
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input taken while a transaction is in work");

endmodule

FILE: dv/tb_weighted_sample_statistics_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_sample_statistics_unit
// Self-checking bench for the weighted sample statistics unit. A directed
// table of extremes and interval corner cases is followed by random sample
// streams under several interval lengths. Every result is compared field by
// field with an in-bench statistics predictor. Both channels idle at random,
// and once the result side holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_weighted_sample_statistics_unit;

    localparam int          PERIOD    = 12;
    localparam longint      LIMIT     = 6000000;
    localparam int          HOLD_AT   = 500;
    localparam int          HOLD_LEN  = 3000;
    localparam int          PHASE_LEN = 350;
    localparam logic [wss_pkg::ADDR_W-1:0] REG_INTERVAL_LENGTH = wss_pkg::ADDR_W'(0);

    typedef enum logic { CMD_ADD = 1'b0, CMD_RESTART = 1'b1 } cmd_t;

    typedef struct {
        logic [wss_pkg::ACC_W-1:0]         total_weight;
        logic signed [15:0]                minimum;
        logic signed [15:0]                maximum;
        logic signed [wss_pkg::MEAN_W-1:0] mean;
        logic signed [wss_pkg::MEAN_W-1:0] interval_mean;
        logic [wss_pkg::VAR_W-1:0]         variance;
        logic [wss_pkg::DEV_W-1:0]         deviation;
    } stats_t;

    typedef struct {
        cmd_t               cmd;
        logic signed [15:0] smp;
        logic [15:0]        wgt;
        logic [31:0]        tnow;
        bit                 known;
    } row_t;

    logic                              clk;
    logic                              rst_n;
    logic                              item_valid;
    logic                              item_stall;
    logic                              command;
    logic signed [15:0]                sample;
    logic [wss_pkg::WEIGHT_W-1:0]      weight;
    logic [wss_pkg::TIME_W-1:0]        now;
    logic                              result_valid;
    logic                              result_stall;
    logic [wss_pkg::ACC_W-1:0]         total_weight;
    logic signed [15:0]                minimum;
    logic signed [15:0]                maximum;
    logic signed [wss_pkg::MEAN_W-1:0] mean;
    logic signed [wss_pkg::MEAN_W-1:0] interval_mean;
    logic [wss_pkg::VAR_W-1:0]         variance;
    logic [wss_pkg::DEV_W-1:0]         deviation;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [wss_pkg::ADDR_W-1:0]        paddr;
    logic [wss_pkg::DATA_W-1:0]        pwdata;
    logic [wss_pkg::DATA_W-1:0]        prdata;
    logic                              pready;

    // predictor state
    logic [31:0]  cfg_len;
    logic [47:0]  p_wtotal;
    longint       p_min;
    longint       p_max;
    longint       p_wsum;
    logic [63:0]  p_sqsum;
    logic [63:0]  p_iend;
    longint       p_isum;
    logic [47:0]  p_iweight;
    longint       p_imean;

    stats_t       pending_stats[$];
    row_t         dir_rows[$];
    longint       cycles;
    int           errors;
    int           n_items;
    int           n_results;
    int           n_restarts;
    int           n_closes;
    int           max_gap;
    int           rx_max_gap;
    logic [31:0]  t_cur;

    weighted_sample_statistics_unit i_dut (.*);

    // clock
    always
    begin
        clk = 1'b1;
        #(PERIOD / 2);
        clk = 1'b0;
        #(PERIOD / 2);
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint sat_s48_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > (64'sd1 <<< 47) - 1)
        begin
            s = (64'sd1 <<< 47) - 1;
        end
        else if (s < -(64'sd1 <<< 47))
        begin
            s = -(64'sd1 <<< 47);
        end
        return s;
    endfunction

    function automatic logic [47:0] sat_u48_add(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? '1 : s[47:0];
    endfunction

    // truncated fixed-point quotient, clamped to the signed 24-bit range
    function automatic logic signed [wss_pkg::MEAN_W-1:0] fixed_mean(longint sum,
                                                                     logic [63:0] den);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] res;
        if (den == 0)
        begin
            return '0;
        end
        neg = sum < 0;
        mag = neg ? -sum : sum;
        q = mag / den;
        r = mag % den;
        if (q > 64'd32768)
        begin
            res = 64'd1 << 23;
        end
        else
        begin
            res = (q << 8) + ((r << 8) / den);
        end
        if (res > (64'd1 << 23))
        begin
            res = 64'd1 << 23;
        end
        if (neg)
        begin
            return -res[23:0];
        end
        if (res > (64'd1 << 23) - 1)
        begin
            res = (64'd1 << 23) - 1;
        end
        return res[23:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] t;
        res = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = res | (64'd1 << b);
            if (t * t <= x)
            begin
                res = t;
            end
        end
        return res;
    endfunction

    function automatic logic [wss_pkg::VAR_W-1:0] weighted_variance();
        logic [135:0] a;
        logic [135:0] b;
        logic [135:0] d;
        logic [63:0]  mag;
        if (p_wtotal <= 1)
        begin
            return '0;
        end
        mag = p_wsum < 0 ? -p_wsum : p_wsum;
        a = 136'(p_sqsum) * 136'(p_wtotal);
        b = 136'(mag) * 136'(mag);
        if (a <= b)
        begin
            return '0;
        end
        d = (a - b) << 8;
        d = d / 136'(p_wtotal);
        d = d / (136'(p_wtotal) + 1);
        if (d > 136'({wss_pkg::VAR_W{1'b1}}))
        begin
            return '1;
        end
        return d[wss_pkg::VAR_W-1:0];
    endfunction

    function automatic logic [63:0] eff_length();
        return (cfg_len == 0) ? 64'd1 : 64'(cfg_len);
    endfunction

    function automatic void clear_statistics(logic [31:0] t);
        logic [63:0] e;
        p_wtotal  = '0;
        p_min     = 0;
        p_max     = 0;
        p_wsum    = 0;
        p_sqsum   = '0;
        p_isum    = 0;
        p_iweight = '0;
        p_imean   = 0;
        e = 64'(t) + eff_length();
        p_iend = (e > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : e;
    endfunction

    // statistics after one transaction
    function automatic stats_t update_statistics(row_t it);
        stats_t      o;
        longint      s;
        longint      prod;
        logic [63:0] pm;
        logic [63:0] sq;
        logic [64:0] sqs;
        logic [63:0] k;
        logic [63:0] ne;
        logic [wss_pkg::VAR_W-1:0] v;
        logic [63:0] dv;
        s = it.smp;
        if (it.cmd == CMD_RESTART)
        begin
            clear_statistics(it.tnow);
        end
        else
        begin
            prod = s * longint'(it.wgt);
            pm = prod < 0 ? -prod : prod;
            sq = (pm >= (64'd1 << 32)) ? '1 : pm * pm;
            if (p_wtotal == 0)
            begin
                p_min = s;
                p_max = s;
            end
            else if (s < p_min)
            begin
                p_min = s;
            end
            else if (s > p_max)
            begin
                p_max = s;
            end
            p_wtotal = sat_u48_add(p_wtotal, 48'(it.wgt));
            p_wsum = sat_s48_add(p_wsum, prod);
            sqs = {1'b0, p_sqsum} + {1'b0, sq};
            p_sqsum = sqs[64] ? '1 : sqs[63:0];
            if (64'(it.tnow) >= p_iend)
            begin
                k = (64'(it.tnow) - p_iend) / eff_length() + 1;
                ne = p_iend + k * eff_length();
                p_imean = (k == 1) ? fixed_mean(p_isum, 64'(p_iweight)) : 0;
                p_isum = 0;
                p_iweight = '0;
                p_iend = (ne > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : ne;
                n_closes++;
            end
            p_isum = sat_s48_add(p_isum, prod);
            p_iweight = sat_u48_add(p_iweight, 48'(it.wgt));
        end
        v = weighted_variance();
        dv = int_sqrt(64'(v));
        o.total_weight  = p_wtotal;
        o.minimum       = (p_wtotal != 0) ? 16'(p_min) : '0;
        o.maximum       = (p_wtotal != 0) ? 16'(p_max) : '0;
        o.mean          = fixed_mean(p_wsum, 64'(p_wtotal));
        o.interval_mean = 24'(p_imean);
        o.variance      = v;
        o.deviation     = (dv > 64'hFFFF_FFFF) ? '1 : dv[31:0];
        return o;
    endfunction

    // configuration writes over the register port
    task automatic write_interval_length(logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_INTERVAL_LENGTH;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== val)
        begin
            $error("interval_length readback expected %0h actual %0h", val, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_len = val;
    endtask

    // offer one transaction, wait for acceptance, record the prediction
    task automatic send_item(row_t it);
        int gap;
        stats_t exp_stats;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        command    <= it.cmd;
        sample     <= it.smp;
        weight     <= it.wgt;
        now        <= it.tnow;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        exp_stats = update_statistics(it);
        if (it.known)
        begin
            exp_stats = '{default: '0};
        end
        pending_stats.push_back(exp_stats);
        n_items++;
        if (it.cmd == CMD_RESTART)
        begin
            n_restarts++;
        end
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        wait (pending_stats.size() == 0);
        @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // random stream: mostly time-ordered adds, some restarts
    task automatic random_phase(int count);
        row_t it;
        logic [32:0] nt;
        for (int i = 0; i < count; i++)
        begin
            it.known = 1'b0;
            it.smp   = 16'($urandom);
            case ($urandom_range(0, 7))
                0:       it.wgt = '0;
                1, 2:    it.wgt = 16'($urandom_range(1, 8));
                default: it.wgt = 16'($urandom);
            endcase
            if ($urandom_range(0, 19) == 0)
            begin
                it.cmd = CMD_RESTART;
                t_cur = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200)
                                                     : $urandom;
            end
            else
            begin
                it.cmd = CMD_ADD;
                case ($urandom_range(0, 5))
                    0:       nt = 33'(t_cur);
                    1:       nt = 33'(t_cur) + $urandom_range(0, 100000);
                    2:       nt = 33'(t_cur) + $urandom;
                    default: nt = 33'(t_cur) + $urandom_range(0, 300);
                endcase
                t_cur = nt[32] ? 32'hFFFF_FFFF : nt[31:0];
            end
            it.tnow = t_cur;
            send_item(it);
        end
    endtask

    // result side: random stalls and one long hold-off
    initial
    begin
        int gap;
        result_stall = 1'b1;
        wait (rst_n);
        forever
        begin
            gap = $urandom_range(0, rx_max_gap);
            if (n_results == HOLD_AT)
            begin
                gap = HOLD_LEN;
            end
            if (gap > 0)
            begin
                @(posedge clk);
                result_stall <= 1'b1;
                repeat (gap - 1) @(posedge clk);
            end
            @(posedge clk);
            result_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!result_valid);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        stats_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            n_results <= n_results + 1;
            if (pending_stats.size() == 0)
            begin
                $error("result with no transaction pending");
                errors++;
            end
            else
            begin
                e = pending_stats.pop_front();
                if (total_weight !== e.total_weight)
                begin
                    $error("total_weight expected %0d actual %0d", e.total_weight, total_weight);
                    errors++;
                end
                if (minimum !== e.minimum)
                begin
                    $error("minimum expected %0d actual %0d", e.minimum, minimum);
                    errors++;
                end
                if (maximum !== e.maximum)
                begin
                    $error("maximum expected %0d actual %0d", e.maximum, maximum);
                    errors++;
                end
                if (mean !== e.mean)
                begin
                    $error("mean expected %0d actual %0d", e.mean, mean);
                    errors++;
                end
                if (interval_mean !== e.interval_mean)
                begin
                    $error("interval_mean expected %0d actual %0d",
                           e.interval_mean, interval_mean);
                    errors++;
                end
                if (variance !== e.variance)
                begin
                    $error("variance expected %0d actual %0d", e.variance, variance);
                    errors++;
                end
                if (deviation !== e.deviation)
                begin
                    $error("deviation expected %0d actual %0d", e.deviation, deviation);
                    errors++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        logic [31:0] lengths[5];
        cycles = 0;
        errors = 0;
        n_items = 0;
        n_results = 0;
        n_restarts = 0;
        n_closes = 0;
        max_gap = 13;
        rx_max_gap = 13;
        t_cur = 0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        command = CMD_ADD;
        sample = '0;
        weight = '0;
        now = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_len = wss_pkg::INTERVAL_RESET;
        clear_statistics(32'd0);
        p_iend = 64'd1000;

        // directed rows: zeroed results are typed in, the rest predicted
        dir_rows = '{
            '{CMD_RESTART, 16'sd0,      16'd0,     32'd0,          1'b1},
            '{CMD_ADD,     16'sd5,      16'd0,     32'd10,         1'b1},
            '{CMD_ADD,     -16'sd32768, 16'hFFFF,  32'd20,         1'b0},
            '{CMD_ADD,     16'sd32767,  16'hFFFF,  32'd30,         1'b0},
            '{CMD_ADD,     16'sd0,      16'd1,     32'd999,        1'b0},
            '{CMD_ADD,     16'sd1,      16'd1,     32'd1000,       1'b0},
            '{CMD_ADD,     -16'sd1,     16'd2,     32'd5000,       1'b0},
            '{CMD_ADD,     16'sd100,    16'd3,     32'd5001,       1'b0},
            '{CMD_ADD,     16'sh5555,   16'hAAAA,  32'd6000,       1'b0},
            '{CMD_ADD,     16'shAAAA,   16'h5555,  32'd6100,       1'b0},
            '{CMD_ADD,     16'sd7,      16'd0,     32'd6200,       1'b0},
            '{CMD_ADD,     16'sd3,      16'd1,     32'd100,        1'b0},
            '{CMD_RESTART, 16'sd9,      16'd9,     32'hFFFF_FC00,  1'b1},
            '{CMD_ADD,     16'sd7,      16'd10,    32'hFFFF_FFFF,  1'b0},
            '{CMD_ADD,     16'sd8,      16'd10,    32'hFFFF_FFFF,  1'b0},
            '{CMD_ADD,     -16'sd8,     16'd1,     32'hFFFF_FFFF,  1'b0},
            '{CMD_RESTART, -16'sd1,     16'hFFFF,  32'd0,          1'b1},
            '{CMD_ADD,     16'sd1,      16'd1,     32'd0,          1'b0},
            '{CMD_ADD,     16'sd1,      16'd1,     32'd1,          1'b0}
        };
        lengths = '{32'd1, 32'hFFFF_FFFF, 32'd37, 32'd0, 32'd0};
        lengths[4] = $urandom_range(2, 5000);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i]);
        end
        t_cur = 0;

        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            write_interval_length(lengths[ph]);
            // one phase runs with no idling on either side
            max_gap = (ph == 2) ? 0 : 13;
            rx_max_gap = (ph == 2) ? 0 : 13;
            random_phase(PHASE_LEN);
        end
        max_gap = 13;
        rx_max_gap = 13;
        drain();
        write_interval_length(wss_pkg::INTERVAL_RESET);

        wait (pending_stats.size() == 0);
        repeat (700) @(posedge clk);
        $display("covered %0d transactions (%0d restarts), %0d interval closes,",
                 n_items, n_restarts, n_closes);
        $display("six interval lengths including 0, 1 and the maximum");
        if (errors == 0 && pending_stats.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
